// ===== design/assert_macros.svh =====
// Assertion macros shared by the bob deinterlacer RTL.
// Needs only a clock and an active-low reset at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define BOBDI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define BOBDI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BOBDI_ASSERT(label, clk, rst_n, prop, msg)
`define BOBDI_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/bobdi_pkg.sv =====
// Package of the bob deinterlacer: register indexes, reset values and the
// control word passed from the front end to the result emitter. No dependencies.
`default_nettype none

package bobdi_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_FIELD = 2'd2;

    // Register values after reset.
    localparam int LINE_BYTES_RESET = 2560;
    localparam int FRAME_ROWS_RESET = 480;

    // Per-byte decode: kept byte, first result is an average, result count.
    typedef struct packed {
        logic       kept;
        logic       first_avg;
        logic [1:0] count;
    } bobdi_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bobdi_if.sv =====
// Stream interfaces of the bob deinterlacer: source pixel bytes in and
// placed result bytes out. Valid/ready handshake; no other dependencies.
`default_nettype none

interface bobdi_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bobdi_result_if #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_ROWS       = 2048
);
    logic                        valid;
    logic                        ready;
    logic [7:0]                  out_value;
    logic [$clog2(MAX_ROWS)-1:0] out_row;
    logic [$clog2(MAX_LINE_BYTES)-1:0] out_col;
    logic                        last_of_run;

    modport source (output valid, output out_value, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_value, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/bob_deinterlacer.sv =====
// Top level of the bob deinterlacer with line averaging.
// Uses bobdi_pkg, bobdi_if, bobdi_ram, bobdi_front, bobdi_emit and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Source bytes arrive in raster order; bytes of the unselected field are
// taken and produce no transaction. A kept byte produces two result
// transactions, one on the first field row of the top field and three on its
// last (two when that row is both), issued one per cycle from the output
// register while the result side is ready. With the result side always ready
// a kept byte is therefore taken only as fast as its results are issued. An
// accepted byte is registered by the line store read and the holding stage,
// and loads the output register once that is free.
// The line store is a single RAM of MAX_LINE_BYTES bytes, read and written
// at the same column when a kept byte is taken; it is not cleared after
// reset, so the first kept row of a frame must precede any averaging.
// The user must write registers only while the block is idle; the block itself does not enforce this.
module bob_deinterlacer #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_ROWS       = 2048
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [bobdi_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [((($clog2(MAX_LINE_BYTES)) > ($clog2(MAX_ROWS))) ?
                   $clog2(MAX_LINE_BYTES) : $clog2(MAX_ROWS)):0] cfg_data,
    bobdi_pixel_if.sink                               pixel,
    bobdi_result_if.source                            result
);

    import bobdi_pkg::*;

    localparam int CW    = $clog2(MAX_LINE_BYTES);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CFG_W = ((CW > RW) ? CW : RW) + 1;

    logic          take;
    logic          slot_free;
    bobdi_ctrl_t   ctrl;
    logic [RW-1:0] first_row;
    logic [CW-1:0] col;
    logic [7:0]    pix;
    logic [7:0]    prev_pix;
    logic          store_access;

    // Counters, registers and decode.
    bobdi_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_ROWS       (MAX_ROWS),
        .CFG_W          (CFG_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .slot_free (slot_free),
        .take      (take),
        .ctrl      (ctrl),
        .first_row (first_row),
        .col       (col),
        .pix       (pix)
    );

    // Line store: previous kept row read out while this row's byte replaces it.
    assign store_access = take && ctrl.kept;

    bobdi_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (store_access),
        .waddr (col),
        .wdata (pix),
        .re    (store_access),
        .raddr (col),
        .rdata (prev_pix)
    );

    // Averaging and result sequencing.
    bobdi_emit #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_ROWS       (MAX_ROWS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (store_access),
        .ctrl      (ctrl),
        .first_row (first_row),
        .col       (col),
        .pix       (pix),
        .prev_pix  (prev_pix),
        .slot_free (slot_free),
        .result    (result)
    );

    // A kept byte always decodes to at least one result.
    `BOBDI_ASSERT(a_kept_has_results, clk, rst_n, store_access |-> ctrl.count != 2'd0, "kept byte with no results")
    // A run that has not ended keeps the output valid in the next cycle.
    `BOBDI_ASSERT(a_run_continues, clk, rst_n, result.valid && result.ready && !result.last_of_run |=> result.valid, "result run broken")
    // The input stalls only behind a pending result.
    `BOBDI_ASSERT_NEVER(a_stall_without_result, clk, rst_n, pixel.valid && !pixel.ready && !result.valid, "input stalled with no result pending")

endmodule

`default_nettype wire

// ===== design/bobdi_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module bobdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read before write; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/bobdi_front.sv =====
// Front end of the bob deinterlacer: configuration registers, raster
// position counters and per-byte result decode. Uses bobdi_pkg and bobdi_if.
`default_nettype none

module bobdi_front #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_ROWS       = 2048,
    parameter int CFG_W          = 13
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bobdi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]                       cfg_data,
    bobdi_pixel_if.sink                            pixel,
    input  logic                                   slot_free,
    output logic                                   take,
    output bobdi_pkg::bobdi_ctrl_t                 ctrl,
    output logic [$clog2(MAX_ROWS)-1:0]            first_row,
    output logic [$clog2(MAX_LINE_BYTES)-1:0]      col,
    output logic [7:0]                             pix
);

    import bobdi_pkg::*;

    localparam int CW   = $clog2(MAX_LINE_BYTES);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int LBW  = CW + 1;
    localparam int HBW  = RW + 1;
    localparam int HMAX = (MAX_ROWS / 2) * 2;
    localparam int STRIDE_RST =
        (LINE_BYTES_RESET > MAX_LINE_BYTES) ? MAX_LINE_BYTES : LINE_BYTES_RESET;
    localparam int HEIGHT_RST = (FRAME_ROWS_RESET > HMAX) ? HMAX : FRAME_ROWS_RESET;

    logic [LBW-1:0] stride_reg;
    logic [HBW-1:0] height_reg;
    logic           bottom_reg;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;

    logic [LBW-1:0] stride_in;
    logic [LBW-1:0] stride_clamped;
    logic [HBW-1:0] height_in;
    logic [HBW-1:0] height_clamped;

    logic           col_over;
    logic [CW-1:0]  col_cur;
    logic [HBW-1:0] row_inc;
    logic [RW-1:0]  row_cur;
    logic [LBW-1:0] col_inc;
    logic           col_end;
    logic [HBW-1:0] row_step;
    logic           row_zero_pair;
    logic           last_pair;

    // Out-of-range stride and height are clamped as they are written.
    always_comb
    begin
        stride_in = cfg_data[LBW-1:0];
        if (stride_in == '0)
            stride_clamped = LBW'(1);
        else if (stride_in > LBW'(MAX_LINE_BYTES))
            stride_clamped = LBW'(MAX_LINE_BYTES);
        else
            stride_clamped = stride_in;

        height_in = {cfg_data[HBW-1:1], 1'b0};
        if (height_in == '0)
            height_clamped = HBW'(2);
        else if (height_in > HBW'(HMAX))
            height_clamped = HBW'(HMAX);
        else
            height_clamped = height_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= LBW'(STRIDE_RST);
            height_reg <= HBW'(HEIGHT_RST);
            bottom_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_BYTES:   stride_reg <= stride_clamped;
                REG_FRAME_ROWS:   height_reg <= height_clamped;
                REG_BOTTOM_FIELD: bottom_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Position of this byte, with counters left beyond a shrunken geometry
    // folded back to the next row or a new frame, and position of the next byte.
    always_comb
    begin
        col_over = {1'b0, col_reg} >= stride_reg;
        col_cur  = col_over ? '0 : col_reg;
        row_inc  = {1'b0, row_reg} + HBW'(col_over);
        row_cur  = (row_inc >= height_reg) ? '0 : row_inc[RW-1:0];

        col_inc  = {1'b0, col_cur} + LBW'(1);
        col_end  = col_inc >= stride_reg;
        row_step = {1'b0, row_cur} + HBW'(1);
        if (!col_end)
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end
        else
        begin
            col_next = '0;
            row_next = (row_step >= height_reg) ? '0 : row_step[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Result decode. The results of one byte go to consecutive rows starting
    // at first_row; only the first of them can be an average.
    always_comb
    begin
        row_zero_pair  = row_cur[RW-1:1] == '0;
        last_pair      = {1'b0, row_cur} == (height_reg - HBW'(2));
        ctrl.kept      = row_cur[0] == bottom_reg;
        ctrl.first_avg = !row_zero_pair;
        first_row      = row_zero_pair ? '0 : row_cur - RW'(1);
        if (bottom_reg)
            ctrl.count = 2'd2;
        else
            ctrl.count = (row_zero_pair ? 2'd1 : 2'd2) + {1'b0, last_pair};
    end

    assign pixel.ready = slot_free;
    assign take        = pixel.valid && slot_free;
    assign col         = col_cur;
    assign pix         = pixel.pixel_byte;

endmodule

`default_nettype wire

// ===== design/bobdi_emit.sv =====
// Result emitter of the bob deinterlacer: a holding stage that waits for the
// line store read, and an output stage that issues one result per cycle while ready.
`default_nettype none

module bobdi_emit #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int MAX_ROWS       = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  bobdi_pkg::bobdi_ctrl_t            ctrl,
    input  logic [$clog2(MAX_ROWS)-1:0]       first_row,
    input  logic [$clog2(MAX_LINE_BYTES)-1:0] col,
    input  logic [7:0]                        pix,
    input  logic [7:0]                        prev_pix,
    output logic                              slot_free,
    bobdi_result_if.source                    result
);

    import bobdi_pkg::*;

    localparam int CW = $clog2(MAX_LINE_BYTES);
    localparam int RW = $clog2(MAX_ROWS);

    // Holding stage: waits for the line store read of the previous row's byte.
    logic          b_valid_reg;
    bobdi_ctrl_t   b_ctrl_reg;
    logic [RW-1:0] b_row_reg;
    logic [CW-1:0] b_col_reg;
    logic [7:0]    b_pix_reg;

    // Output stage.
    logic          c_valid_reg;
    logic [1:0]    c_left_reg;
    logic [RW-1:0] c_row_reg;
    logic [CW-1:0] c_col_reg;
    logic [7:0]    c_pix_reg;
    logic [7:0]    c_val_reg;

    logic          out_take;
    logic          c_last;
    logic          c_free;
    logic          b_move;
    logic [8:0]    avg_sum;

    assign out_take  = result.valid && result.ready;
    assign c_last    = c_left_reg == 2'd0;
    assign c_free    = !c_valid_reg || (out_take && c_last);
    assign b_move    = b_valid_reg && c_free;
    assign slot_free = !b_valid_reg || b_move;
    assign avg_sum   = {1'b0, b_pix_reg} + {1'b0, prev_pix};

    // Stage occupancy and remaining result count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_left_reg  <= 2'd0;
        end
        else
        begin
            if (load)
                b_valid_reg <= 1'b1;
            else if (b_move)
                b_valid_reg <= 1'b0;

            if (b_move)
            begin
                c_valid_reg <= 1'b1;
                c_left_reg  <= b_ctrl_reg.count - 2'd1;
            end
            else if (out_take)
            begin
                if (c_last)
                    c_valid_reg <= 1'b0;
                c_left_reg <= c_left_reg - 2'd1;
            end
        end
    end

    // Payload; after each transaction the row steps and the value turns to the copy.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_ctrl_reg <= ctrl;
            b_row_reg  <= first_row;
            b_col_reg  <= col;
            b_pix_reg  <= pix;
        end
        if (b_move)
        begin
            c_row_reg <= b_row_reg;
            c_col_reg <= b_col_reg;
            c_pix_reg <= b_pix_reg;
            c_val_reg <= b_ctrl_reg.first_avg ? avg_sum[8:1] : b_pix_reg;
        end
        else if (out_take)
        begin
            c_row_reg <= c_row_reg + RW'(1);
            c_val_reg <= c_pix_reg;
        end
    end

    assign result.valid       = c_valid_reg;
    assign result.out_value   = c_val_reg;
    assign result.out_row     = c_row_reg;
    assign result.out_col     = c_col_reg;
    assign result.last_of_run = c_last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_bob_deinterlacer.sv =====
// Self-checking testbench of the bob deinterlacer: drives pixel bytes, predicts every
// placed result byte and compares it with the result stream. Needs bobdi_pkg, bobdi_if
// and the bob_deinterlacer RTL.
module tb_bob_deinterlacer;
    import bobdi_pkg::*;

    localparam int MAX_LINE_BYTES = 4096;
    localparam int MAX_ROWS       = 2048;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PIXELS  = 180;
    localparam int IDLE_PERCENT   = 29;

    // One placed byte as it appears on the result stream.
    typedef struct packed {
        logic [7:0]  value;
        logic [10:0] row;
        logic [11:0] col;
        logic        last_of_run;
    } placed_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [12:0] cfg_data;

    bobdi_pixel_if pix_if ();
    bobdi_result_if #(.MAX_LINE_BYTES(MAX_LINE_BYTES), .MAX_ROWS(MAX_ROWS)) res_if ();

    bob_deinterlacer #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES),
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pix_if),
        .result(res_if)
    );

    // Shadow copy of the geometry registers and the raster position.
    logic [12:0] shadow_line_bytes = 13'(LINE_BYTES_RESET);
    logic [11:0] shadow_frame_rows = 12'(FRAME_ROWS_RESET);
    logic        shadow_bottom     = 1'b0;
    logic [12:0] col_pos = '0;
    logic [11:0] row_pos = '0;
    logic [7:0]  prev_field_row [MAX_LINE_BYTES];

    placed_byte_t placed_due[$];
    int  fault_count  = 0;
    int  pixels_sent  = 0;
    int  holds_asked  = 0;
    bit  pace_on      = 1'b1;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Queue one expected placed byte.
    function automatic void add_placed(input logic [7:0] v, input int unsigned r,
                                       input int unsigned c);
        placed_byte_t item;
        item.value       = v;
        item.row         = 11'(r);
        item.col         = 12'(c);
        item.last_of_run = 1'b0;
        placed_due.push_back(item);
    endfunction

    // Advance the raster position by one byte and queue the bytes it places.
    task automatic deinterlace_pixel(input logic [7:0] px);
        int unsigned stride;
        int unsigned height;
        int unsigned fields;
        int unsigned j;
        logic [12:0] col;
        logic [11:0] row;
        logic [8:0]  pair_sum;
        stride = 32'(shadow_line_bytes);
        if (stride == 0)
            stride = 1;
        if (stride > MAX_LINE_BYTES)
            stride = MAX_LINE_BYTES;
        height = 32'({shadow_frame_rows[11:1], 1'b0});
        if (height == 0)
            height = 2;
        if (height > MAX_ROWS)
            height = MAX_ROWS;

        // A position left beyond a shrunken geometry wraps first.
        if (col_pos >= stride)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        if (row_pos >= height)
            row_pos = '0;
        col = col_pos;
        row = row_pos;

        col_pos = col_pos + 1'b1;
        if (col_pos >= stride)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            if (row_pos >= height)
                row_pos = '0;
        end

        // Bytes of the other field place nothing.
        if (row[0] != shadow_bottom)
            return;

        j = 32'(row >> 1);
        fields = height >> 1;
        pair_sum = {1'b0, px} + {1'b0, prev_field_row[col[11:0]]};
        if (!shadow_bottom)
        begin
            if (j == 0)
                add_placed(px, 0, 32'(col));
            else
            begin
                add_placed(pair_sum[8:1], 2 * j - 1, 32'(col));
                add_placed(px, 2 * j, 32'(col));
            end
            if (j == fields - 1)
                add_placed(px, height - 1, 32'(col));
        end
        else
        begin
            if (j == 0)
                add_placed(px, 0, 32'(col));
            else
                add_placed(pair_sum[8:1], 2 * j, 32'(col));
            add_placed(px, 2 * j + 1, 32'(col));
        end
        prev_field_row[col[11:0]] = px;
        placed_due[placed_due.size() - 1].last_of_run = 1'b1;
    endtask

    // Result side: random ready, long hold-offs on request, and the field checks.
    initial
    begin
        int holds_served;
        int hold_left;
        placed_byte_t want;
        holds_served = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (placed_due.size() == 0)
                begin
                    $error("unexpected result transaction: row %0d col %0d value %0d",
                           res_if.out_row, res_if.out_col, res_if.out_value);
                    fault_count++;
                end
                else
                begin
                    want = placed_due.pop_front();
                    if (res_if.out_value !== want.value)
                    begin
                        $error("out_value: expected %0d, got %0d", want.value, res_if.out_value);
                        fault_count++;
                    end
                    if (res_if.out_row !== want.row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.row, res_if.out_row);
                        fault_count++;
                    end
                    if (res_if.out_col !== want.col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.col, res_if.out_col);
                        fault_count++;
                    end
                    if (res_if.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                               res_if.last_of_run);
                        fault_count++;
                    end
                end
            end
            if (holds_served != holds_asked)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= !pace_on || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Write all three geometry registers, one per clock.
    task automatic write_geometry(input logic [12:0] stride, input logic [11:0] rows,
                                  input logic bottom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINE_BYTES;
        cfg_data  <= stride;
        @(posedge clk);
        cfg_index <= REG_FRAME_ROWS;
        cfg_data  <= 13'(rows);
        @(posedge clk);
        cfg_index <= REG_BOTTOM_FIELD;
        cfg_data  <= 13'(bottom);
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_line_bytes = stride;
        shadow_frame_rows = rows;
        shadow_bottom     = bottom;
    endtask

    // Offer one pixel byte, with an occasional gap, and predict it once taken.
    task automatic send_pixel(input logic [7:0] px);
        if (pace_on && ($urandom_range(99) < IDLE_PERCENT))
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel_byte <= px;
        do
            @(posedge clk);
        while (!pix_if.ready);
        deinterlace_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(8'($urandom_range(255)));
    endtask

    // Random bytes until the raster position is back at the start of a frame.
    task automatic send_to_frame_start();
        do
            send_pixel(8'($urandom_range(255)));
        while (!(col_pos == 0 && row_pos == 0));
    endtask

    // Stop offering and wait until every expected byte has come out.
    task automatic wait_drain();
        pix_if.valid <= 1'b0;
        while (placed_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset geometry, then a shrink that leaves the column beyond the new stride.
    task automatic test_reset_geometry();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        wait_drain();
        write_geometry(13'd2, 12'd4, 1'b0);
        send_to_frame_start();
        wait_drain();
    endtask

    // Byte extremes through the copy and the floor average.
    task automatic test_pixel_extremes();
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h00);
        wait_drain();
    endtask

    // Bottom field, and odd heights whose low bit is dropped.
    task automatic test_field_parity();
        write_geometry(13'd3, 12'd4, 1'b1);
        send_to_frame_start();
        wait_drain();
        write_geometry(13'd2, 12'd7, 1'b0);
        send_to_frame_start();
        wait_drain();
        write_geometry(13'd2, 12'd5, 1'b1);
        send_to_frame_start();
        wait_drain();
    endtask

    // Out-of-range and extreme register values.
    task automatic test_geometry_limits();
        // Zero stride acts as one, zero and one heights act as two.
        write_geometry(13'd0, 12'd0, 1'b0);
        send_to_frame_start();
        wait_drain();
        write_geometry(13'd0, 12'd1, 1'b1);
        send_to_frame_start();
        wait_drain();

        // Stride above the maximum, then shrunk mid-row.
        write_geometry(13'h1FFF, 12'd4, 1'b0);
        send_random(4);
        wait_drain();
        write_geometry(13'd2, 12'd4, 1'b0);
        send_to_frame_start();
        wait_drain();

        // Maximum stride on the bottom field; these bytes place nothing.
        write_geometry(13'(MAX_LINE_BYTES), 12'd4, 1'b1);
        send_random(3);
        wait_drain();
        write_geometry(13'd2, 12'd4, 1'b1);
        send_to_frame_start();
        wait_drain();

        // Height above the maximum, then shrunk so the row wraps to a new frame.
        write_geometry(13'd1, 12'hFFF, 1'b0);
        send_random(3);
        wait_drain();
        write_geometry(13'd1, 12'd2, 1'b0);
        send_to_frame_start();
        wait_drain();

        // Maximum height exactly.
        write_geometry(13'd3, 12'(MAX_ROWS), 1'b1);
        send_random(9);
        wait_drain();
        write_geometry(13'd3, 12'd2, 1'b1);
        send_to_frame_start();
        wait_drain();
    endtask

    // Result side held off while bytes keep coming, then a pause mid-frame.
    task automatic test_backpressure();
        write_geometry(13'd6, 12'd6, 1'b0);
        holds_asked++;
        send_to_frame_start();
        send_random(10);
        wait_drain();
        send_to_frame_start();
        wait_drain();
    endtask

    // Whole frames of random small geometries and random content.
    task automatic test_random_frames();
        int start_count;
        int phase;
        logic [12:0] stride;
        start_count = pixels_sent;
        phase = 0;
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            stride = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 12));
            // The first phase is one full-size frame without any idling on either side.
            pace_on = (phase != 0);
            if (phase == 0)
            begin
                write_geometry(13'd12, 12'd8, 1'b0);
                send_to_frame_start();
            end
            else
            begin
                write_geometry(stride, 12'($urandom_range(0, 12)), 1'($urandom_range(1)));
                repeat ($urandom_range(1, 3)) send_to_frame_start();
            end
            wait_drain();
            phase++;
        end
        pace_on = 1'b1;
    endtask

    // Reset, then the tests in turn.
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_LINE_BYTES;
        cfg_data          = '0;
        pix_if.valid      = 1'b0;
        pix_if.pixel_byte = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_pixel_extremes();
        test_field_parity();
        test_geometry_limits();
        test_backpressure();
        test_random_frames();
        wait_drain();

        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== bob_deinterlacer.f =====
+incdir+design
design/bobdi_pkg.sv
design/bobdi_if.sv
design/bobdi_ram.sv
design/bobdi_front.sv
design/bobdi_emit.sv
design/bob_deinterlacer.sv
tb/sv/tb_bob_deinterlacer.sv
